@@ design/ftlf_pkg.sv @@
`timescale 1ns / 1ps

package ftlf_pkg;

    localparam int TIME_BITS   = 48;
    localparam int FN_BITS     = 16;
    localparam int PERIOD_BITS = 24;
    localparam int THR_BITS    = 24;
    localparam int REC_BITS    = 8;
    localparam int STEP_BITS   = PERIOD_BITS + FN_BITS;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int IN_DATA_BITS  = TIME_BITS + FN_BITS;
    localparam int OUT_DATA_BITS = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 3;

    localparam logic [PERIOD_BITS-1:0] RST_FRAME_PERIOD = PERIOD_BITS'(1001000);
    localparam logic [THR_BITS-1:0]    RST_LATE_THR     = THR_BITS'(1000);
    localparam logic [THR_BITS-1:0]    RST_EARLY_THR    = THR_BITS'(3000);
    localparam logic [REC_BITS-1:0]    RST_MAX_RECOVERY = REC_BITS'(10);
    localparam logic [FN_BITS-1:0]     RST_MAX_SKIPPED  = FN_BITS'(100);
    localparam logic [REC_BITS-1:0]    MISS_MAX         = {REC_BITS{1'b1}};

    typedef enum logic [2:0] {
        REG_FRAME_PERIOD = 3'd0,
        REG_LATE_THR     = 3'd1,
        REG_EARLY_THR    = 3'd2,
        REG_MAX_RECOVERY = 3'd3,
        REG_MAX_SKIPPED  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] frame_period;
        logic [THR_BITS-1:0]    late_threshold;
        logic [THR_BITS-1:0]    early_threshold;
        logic [REC_BITS-1:0]    recovery_limit;
        logic [FN_BITS-1:0]     skip_limit;
    } t_cfg;

    typedef struct packed {
        logic skip_reset;
        logic lock_lost;
        logic early;
    } t_flags;

endpackage

@@ design/ftlf_regs.sv @@
`timescale 1ns / 1ps

module ftlf_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ftlf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ftlf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ftlf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output ftlf_pkg::t_cfg                     o_cfg
);
    import ftlf_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_FRAME_PERIOD: n_cfg.frame_period    = pwdata[PERIOD_BITS-1:0];
                REG_LATE_THR:     n_cfg.late_threshold  = pwdata[THR_BITS-1:0];
                REG_EARLY_THR:    n_cfg.early_threshold = pwdata[THR_BITS-1:0];
                REG_MAX_RECOVERY: n_cfg.recovery_limit  = pwdata[REC_BITS-1:0];
                REG_MAX_SKIPPED:  n_cfg.skip_limit      = pwdata[FN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FRAME_PERIOD: prdata = APB_DATA_BITS'(r_cfg.frame_period);
            REG_LATE_THR:     prdata = APB_DATA_BITS'(r_cfg.late_threshold);
            REG_EARLY_THR:    prdata = APB_DATA_BITS'(r_cfg.early_threshold);
            REG_MAX_RECOVERY: prdata = APB_DATA_BITS'(r_cfg.recovery_limit);
            REG_MAX_SKIPPED:  prdata = APB_DATA_BITS'(r_cfg.skip_limit);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_period    <= RST_FRAME_PERIOD;
            r_cfg.late_threshold  <= RST_LATE_THR;
            r_cfg.early_threshold <= RST_EARLY_THR;
            r_cfg.recovery_limit  <= RST_MAX_RECOVERY;
            r_cfg.skip_limit      <= RST_MAX_SKIPPED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ design/ftlf_filter.sv @@
`timescale 1ns / 1ps

module ftlf_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  ftlf_pkg::t_cfg                 i_cfg,
    input  logic [ftlf_pkg::TIME_BITS-1:0] i_time,
    input  logic [ftlf_pkg::FN_BITS-1:0]   i_frame,
    output logic [ftlf_pkg::TIME_BITS-1:0] o_time,
    output ftlf_pkg::t_flags               o_flags
);
    import ftlf_pkg::*;

    logic [TIME_BITS-1:0] r_ant_time, n_ant_time;
    logic                 r_ant_valid, n_ant_valid;
    logic [TIME_BITS-1:0] r_rel_time, n_rel_time;
    logic                 r_rel_valid, n_rel_valid;
    logic [REC_BITS-1:0]  r_miss, n_miss;
    logic [FN_BITS-1:0]   r_prev_frame;

    logic [FN_BITS-1:0]   w_gap;
    logic                 w_skip;
    logic                 w_av0, w_rv0;
    logic [REC_BITS-1:0]  w_mc0, w_mc1;
    logic [STEP_BITS-1:0] w_step;
    logic [TIME_BITS-1:0] w_at1, w_rt1, w_rt2, w_late_diff;
    logic                 w_rv2;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                     input logic [STEP_BITS-1:0] s);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, t} + (TIME_BITS+1)'(s);
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

    assign w_gap  = i_frame - r_prev_frame;
    assign w_skip = w_gap > i_cfg.skip_limit;
    assign w_av0  = r_ant_valid && !w_skip;
    assign w_rv0  = r_rel_valid && !w_skip;
    assign w_mc0  = w_skip ? '0 : r_miss;
    assign w_mc1  = (w_mc0 != MISS_MAX) ? w_mc0 + REC_BITS'(1) : w_mc0;
    assign w_step = STEP_BITS'(i_cfg.frame_period) * STEP_BITS'(w_gap);
    assign w_at1  = w_av0 ? sat_add(r_ant_time, w_step) : r_ant_time;
    assign w_rt1  = w_rv0 ? sat_add(r_rel_time, w_step) : r_rel_time;
    assign w_rt2  = (!w_rv0 || i_time < w_rt1) ? i_time : w_rt1;
    assign w_rv2  = 1'b1;
    assign w_late_diff = i_time - w_at1;

    always_comb begin
        n_ant_time       = w_at1;
        n_ant_valid      = w_av0;
        n_rel_time       = w_rt2;
        n_rel_valid      = w_rv2;
        n_miss           = w_mc0;
        o_time           = i_time;
        o_flags.skip_reset = w_skip;
        o_flags.lock_lost  = 1'b0;
        o_flags.early      = w_av0 && (w_at1 > TIME_BITS'(i_cfg.early_threshold))
                             && (i_time < w_at1 - TIME_BITS'(i_cfg.early_threshold));
        priority if (!w_av0 || i_time < w_at1) begin
            n_ant_time  = i_time;
            n_ant_valid = 1'b1;
            n_rel_valid = 1'b0;
            n_miss      = '0;
        end else if (w_late_diff > TIME_BITS'(i_cfg.late_threshold)) begin
            n_miss = w_mc1;
            o_time = w_at1;
            if (w_mc1 > i_cfg.recovery_limit) begin
                n_ant_time        = w_rt2;
                n_ant_valid       = w_rv2;
                n_rel_valid       = 1'b0;
                o_flags.lock_lost = 1'b1;
                o_time            = w_rt2;
            end
        end else begin
            o_time = i_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant_time   <= '0;
            r_ant_valid  <= 1'b0;
            r_rel_time   <= '0;
            r_rel_valid  <= 1'b0;
            r_miss       <= '0;
            r_prev_frame <= '0;
        end else if (i_en) begin
            r_ant_time   <= n_ant_time;
            r_ant_valid  <= n_ant_valid;
            r_rel_time   <= n_rel_time;
            r_rel_valid  <= n_rel_valid;
            r_miss       <= n_miss;
            r_prev_frame <= i_frame;
        end
    end

endmodule

@@ design/frame_timestamp_lock_filter_core.sv @@
`timescale 1ns / 1ps
// datapath: a request passes the input register, then the result register (input register, result register)
// throughput: one request per cycle while the output is not stalled; the filter state loop
//   (multiply-add, saturate, compare) is combinational between input and result registers
// reset: synchronous active low; clears handshake state and filter state, loads
//   register defaults

module frame_timestamp_lock_filter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ftlf_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,   // arrival time, frame id
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ftlf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // filtered time
    output logic [ftlf_pkg::OUT_USER_BITS-1:0] m_axis_tuser,   // early, lock_lost, skip_reset
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ftlf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ftlf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ftlf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import ftlf_pkg::*;

    t_cfg                 w_cfg;
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_in_time;
    logic [FN_BITS-1:0]   r_in_frame;
    logic                 r_out_valid;
    logic [TIME_BITS-1:0] r_out_time;
    t_flags               r_out_flags;
    logic                 w_adv;
    logic [TIME_BITS-1:0] w_res_time;
    t_flags               w_res_flags;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'(r_out_time);
    assign m_axis_tuser  = r_out_flags;

    ftlf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ftlf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cfg   (w_cfg),
        .i_time  (r_in_time),
        .i_frame (r_in_frame),
        .o_time  (w_res_time),
        .o_flags (w_res_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_time  <= s_axis_tdata[TIME_BITS-1:0];
            r_in_frame <= s_axis_tdata[TIME_BITS +: FN_BITS];
        end
        if (w_adv) begin
            r_out_time  <= w_res_time;
            r_out_flags <= w_res_flags;
        end
    end

endmodule

@@ verif/tb_frame_timestamp_lock_filter_core.sv @@
`timescale 1ns / 1ps

module tb_frame_timestamp_lock_filter_core;
    import ftlf_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = {TIME_BITS{1'b1}};
    localparam int PIPE_CYCLES = 2;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_FRAMES = 240;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic [TIME_BITS-1:0] stamp_time;
        t_flags               flags;
    } t_stamp;

    typedef struct packed {
        logic [TIME_BITS-1:0] in_time;
        logic [FN_BITS-1:0]   frame_id;
        logic                 typed;
        logic [TIME_BITS-1:0] want_time;
        t_flags               flags;
    } t_frame_row;

    typedef enum int {
        RX_FREE,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE
    } t_rx_mode;

    localparam t_flags NO_FLAGS   = '0;
    localparam t_flags EARLY_ONLY = '{skip_reset: 1'b0, lock_lost: 1'b0, early: 1'b1};
    localparam t_flags SKIP_ONLY  = '{skip_reset: 1'b1, lock_lost: 1'b0, early: 1'b0};

    // on-time start, early frame, run of late frames ending in lock loss,
    // frame gap reset, time and frame number extremes, wrap, saturation
    localparam int NUM_ROWS = 24;
    localparam t_frame_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{48'd1000000,         16'd0,     1'b1, 48'd1000000, NO_FLAGS},
        '{48'd2001000,         16'd1,     1'b1, 48'd2001000, NO_FLAGS},
        '{48'd2998000,         16'd2,     1'b1, 48'd2998000, EARLY_ONLY},
        '{48'd4000001,         16'd3,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd5005000,         16'd4,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd6002500,         16'd5,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd7032000,         16'd6,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd8005500,         16'd7,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd9005000,         16'd8,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd10013000,        16'd9,     1'b0, 48'd0,       NO_FLAGS},
        '{48'd11007001,        16'd10,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd12011000,        16'd11,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd13014000,        16'd12,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd14012000,        16'd13,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd15012000,        16'd14,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd16013000,        16'd15,    1'b0, 48'd0,       NO_FLAGS},
        '{48'd123456789,       16'd215,   1'b1, 48'd123456789, SKIP_ONLY},
        '{48'hFFFF_FFFF_FFFF,  16'd216,   1'b0, 48'd0,       NO_FLAGS},
        '{48'd0,               16'hFFFF,  1'b1, 48'd0,       SKIP_ONLY},
        '{48'd0,               16'hFFFF,  1'b1, 48'd0,       NO_FLAGS},
        '{48'd1001000,         16'd0,     1'b1, 48'd1001000, NO_FLAGS},
        '{48'hFFFF_FFFF_FF00,  16'd1,     1'b0, 48'd0,       NO_FLAGS},
        '{48'hFFFF_FFFF_FFFF,  16'd50,    1'b0, 48'd0,       NO_FLAGS},
        '{48'hFFFF_FFFF_FFFF,  16'd51,    1'b0, 48'd0,       NO_FLAGS}
    };

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // arrival time, frame id
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // filtered time
    logic [OUT_USER_BITS-1:0] m_axis_tuser;        // early, lock_lost, skip_reset
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    frame_timestamp_lock_filter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // filter mirror
    t_cfg lock_cfg = '{
        frame_period:    RST_FRAME_PERIOD,
        late_threshold:  RST_LATE_THR,
        early_threshold: RST_EARLY_THR,
        recovery_limit:  RST_MAX_RECOVERY,
        skip_limit:      RST_MAX_SKIPPED
    };
    logic [TIME_BITS-1:0] ant_time = '0;
    logic                 ant_ok = 1'b0;
    logic [TIME_BITS-1:0] relock_time = '0;
    logic                 relock_ok = 1'b0;
    logic [REC_BITS-1:0]  miss_count = '0;
    logic [FN_BITS-1:0]   last_frame = '0;

    t_stamp pending_stamps[$];
    int     n_err = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_early = 0;
    int     n_lost = 0;
    int     n_skip = 0;
    int     n_settings = 0;
    int     burst_left = 0;
    bit     hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_stamps.size());
        $display("tb_frame_timestamp_lock_filter_core: FAIL");
        $finish;
    end

    function automatic logic [TIME_BITS-1:0] add_sat(input logic [TIME_BITS-1:0] t,
                                                     input logic [STEP_BITS-1:0] step);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, t} + (TIME_BITS + 1)'(step);
        return sum[TIME_BITS] ? TIME_ALL_ONES : sum[TIME_BITS-1:0];
    endfunction

    function automatic t_stamp stamp_frame(input logic [TIME_BITS-1:0] t_in,
                                           input logic [FN_BITS-1:0] frame_id);
        logic [FN_BITS-1:0]   gap;
        logic [STEP_BITS-1:0] step;
        t_stamp               r;
        gap = frame_id - last_frame;
        r.stamp_time = t_in;
        r.flags = NO_FLAGS;
        if (gap > lock_cfg.skip_limit) begin
            ant_ok = 1'b0;
            relock_ok = 1'b0;
            miss_count = '0;
            r.flags.skip_reset = 1'b1;
        end
        step = STEP_BITS'(lock_cfg.frame_period) * STEP_BITS'(gap);
        if (ant_ok) ant_time = add_sat(ant_time, step);
        if (relock_ok) relock_time = add_sat(relock_time, step);
        if (!relock_ok || t_in < relock_time) begin
            relock_time = t_in;
            relock_ok = 1'b1;
        end
        if (ant_ok && ant_time > TIME_BITS'(lock_cfg.early_threshold) &&
            t_in < ant_time - TIME_BITS'(lock_cfg.early_threshold)) begin
            r.flags.early = 1'b1;
        end
        if (!ant_ok || t_in < ant_time) begin
            ant_time = t_in;
            ant_ok = 1'b1;
            relock_ok = 1'b0;
            miss_count = '0;
        end else if (t_in - ant_time > TIME_BITS'(lock_cfg.late_threshold)) begin
            if (miss_count != MISS_MAX) miss_count++;
            if (miss_count > lock_cfg.recovery_limit) begin
                ant_time = relock_time;
                ant_ok = relock_ok;
                relock_ok = 1'b0;
                r.flags.lock_lost = 1'b1;
            end
            r.stamp_time = ant_time;
        end
        last_frame = frame_id;
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] jittered(input logic [TIME_BITS-1:0] base,
                                                      input longint jit);
        longint v;
        v = longint'({16'd0, base}) + jit;
        if (v < 0) return '0;
        if (v > longint'({16'd0, TIME_ALL_ONES})) return TIME_ALL_ONES;
        return v[TIME_BITS-1:0];
    endfunction

    function automatic void report(input string what, input logic [TIME_BITS-1:0] want,
                                   input logic [TIME_BITS-1:0] got);
        n_err++;
        if (n_err <= 40)
            $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
    endfunction

    always @(posedge i_clk) begin : check_stamps
        t_stamp want;
        t_stamp got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.stamp_time = m_axis_tdata[TIME_BITS-1:0];
            got.flags = m_axis_tuser;
            if (pending_stamps.size() == 0) begin
                n_err++;
                if (n_err <= 40)
                    $display("%0t unexpected result: expected none got %0h flags %b",
                             $time, got.stamp_time, got.flags);
            end else begin
                want = pending_stamps.pop_front();
                n_checked++;
                if (want.stamp_time != got.stamp_time)
                    report("filtered time", want.stamp_time, got.stamp_time);
                if (want.flags.early != got.flags.early)
                    report("early", TIME_BITS'(want.flags.early),
                           TIME_BITS'(got.flags.early));
                if (want.flags.lock_lost != got.flags.lock_lost)
                    report("lock_lost", TIME_BITS'(want.flags.lock_lost),
                           TIME_BITS'(got.flags.lock_lost));
                if (want.flags.skip_reset != got.flags.skip_reset)
                    report("skip_reset", TIME_BITS'(want.flags.skip_reset),
                           TIME_BITS'(got.flags.skip_reset));
                n_early += int'(want.flags.early);
                n_lost += int'(want.flags.lock_lost);
                n_skip += int'(want.flags.skip_reset);
            end
        end
    end

    initial begin : result_stall
        t_rx_mode mode;
        int       span;
        mode = RX_FREE;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge i_clk);
            end
            if (span == 0) begin
                span = $urandom_range(16, 200);
                mode = t_rx_mode'($urandom_range(0, 3));
            end
            span--;
            case (mode)
                RX_FREE:   m_axis_tready <= 1'b1;
                RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_frame(input logic [TIME_BITS-1:0] t, input logic [FN_BITS-1:0] fn,
                              input bit typed, input t_stamp typed_stamp);
        t_stamp r;
        s_axis_tdata <= {fn, t};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = stamp_frame(t, fn);
        pending_stamps.push_back(typed ? typed_stamp : r);
        n_sent++;
    endtask

    task automatic pace();
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (idle != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] wdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_PERIOD: lock_cfg.frame_period = wdata[PERIOD_BITS-1:0];
            REG_LATE_THR:     lock_cfg.late_threshold = wdata[THR_BITS-1:0];
            REG_EARLY_THR:    lock_cfg.early_threshold = wdata[THR_BITS-1:0];
            REG_MAX_RECOVERY: lock_cfg.recovery_limit = wdata[REC_BITS-1:0];
            REG_MAX_SKIPPED:  lock_cfg.skip_limit = wdata[FN_BITS-1:0];
            default: ;
        endcase
    endtask

    // upper bits carry junk, the block keeps only the register width
    task automatic set_config(input logic [PERIOD_BITS-1:0] period,
                              input logic [THR_BITS-1:0] late_thr,
                              input logic [THR_BITS-1:0] early_thr,
                              input logic [REC_BITS-1:0] recovery,
                              input logic [FN_BITS-1:0] skip_limit);
        logic [APB_DATA_BITS-1:0] junk;
        junk = $urandom;
        write_reg(REG_FRAME_PERIOD, {junk[31:24], period});
        write_reg(REG_LATE_THR, {junk[23:16], late_thr});
        write_reg(REG_EARLY_THR, {junk[15:8], early_thr});
        write_reg(REG_MAX_RECOVERY, {junk[31:8], recovery});
        write_reg(REG_MAX_SKIPPED, {junk[31:16], skip_limit});
        n_settings++;
    endtask

    task automatic run_phase(input int n_frames, input bit long_hold);
        logic [TIME_BITS-1:0] nominal;
        logic [TIME_BITS-1:0] t;
        logic [FN_BITS-1:0]   fn;
        logic [FN_BITS-1:0]   gap;
        longint               jit;
        longint               lt;
        int                   late_left;
        int                   rec_cap;
        int                   pick;
        lt = longint'(lock_cfg.late_threshold);
        rec_cap = (lock_cfg.recovery_limit > 20) ? 20 : int'(lock_cfg.recovery_limit);
        late_left = 0;
        fn = FN_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: nominal = TIME_ALL_ONES -
                         TIME_BITS'($urandom_range(0, 40)) * TIME_BITS'(lock_cfg.frame_period);
            1: nominal = {16'($urandom), 32'($urandom)};
            default: nominal = TIME_BITS'($urandom_range(0, 1000000000));
        endcase
        for (int i = 0; i < n_frames; i++) begin
            if (long_hold && i == n_frames / 2) begin
                hold_req = 1'b1;
                burst_left = 48;
            end
            if ($urandom_range(0, 99) < 4) begin
                send_frame({16'($urandom), 32'($urandom)}, FN_BITS'($urandom), 1'b0, '0);
                pace();
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)      gap = FN_BITS'(1);
            else if (pick < 88) gap = '0;
            else if (pick < 94) gap = FN_BITS'($urandom_range(2, 8));
            else if (pick < 97) gap = lock_cfg.skip_limit + FN_BITS'($urandom_range(0, 1));
            else                gap = FN_BITS'($urandom);
            fn += gap;
            nominal = add_sat(nominal, STEP_BITS'(lock_cfg.frame_period) * STEP_BITS'(gap));
            if (late_left > 0) begin
                late_left--;
                jit = lt + 1 + longint'($urandom_range(0, 2000));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    jit = longint'($urandom_range(0, lock_cfg.late_threshold));
                end else if (pick == 6) begin
                    jit = -longint'($urandom_range(0, lock_cfg.early_threshold));
                end else if (pick == 7) begin
                    jit = -(longint'(lock_cfg.early_threshold) + 1 +
                            longint'($urandom_range(0, 2000)));
                end else begin
                    late_left = $urandom_range(1, rec_cap + 3);
                    jit = lt + 1 + longint'($urandom_range(0, lock_cfg.late_threshold + 2000));
                end
            end
            t = jittered(nominal, jit);
            if (jit < 0 && $urandom_range(0, 1) == 1) nominal = t;
            send_frame(t, fn, 1'b0, '0);
            pace();
        end
        drain();
    endtask

    initial begin : stimulus
        t_stamp row_stamp;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row_stamp.stamp_time = DIRECTED_ROWS[r].want_time;
            row_stamp.flags = DIRECTED_ROWS[r].flags;
            send_frame(DIRECTED_ROWS[r].in_time, DIRECTED_ROWS[r].frame_id,
                       DIRECTED_ROWS[r].typed, row_stamp);
            pace();
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_config(RST_FRAME_PERIOD, RST_LATE_THR, RST_EARLY_THR,
                              RST_MAX_RECOVERY, RST_MAX_SKIPPED);
                1: set_config('0, '0, '0, '0, '0);
                2: set_config('1, '1, '1, REC_BITS'(254), '1);
                3: set_config(PERIOD_BITS'(33333), THR_BITS'(500), THR_BITS'(500),
                              MISS_MAX, FN_BITS'(5));
                4: set_config(PERIOD_BITS'(16667), THR_BITS'(200), THR_BITS'(200),
                              REC_BITS'(2), FN_BITS'(3));
                default: set_config(PERIOD_BITS'($urandom_range(1, 2000000)),
                                    THR_BITS'($urandom_range(0, 20000)),
                                    THR_BITS'($urandom_range(0, 20000)),
                                    REC_BITS'($urandom_range(0, 8)),
                                    FN_BITS'($urandom_range(0, 300)));
            endcase
            run_phase(PHASE_FRAMES, p == 2 || p == 5);
        end

        $display("checked %0d of %0d frames across %0d register settings",
                 n_checked, n_sent, n_settings);
        $display("results flagged: %0d early, %0d lock losses, %0d gap resets",
                 n_early, n_lost, n_skip);
        if (n_err == 0 && pending_stamps.size() == 0) begin
            $display("tb_frame_timestamp_lock_filter_core: PASS");
        end else begin
            $display("tb_frame_timestamp_lock_filter_core: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ftlf_pkg.sv
design/ftlf_regs.sv
design/ftlf_filter.sv
design/frame_timestamp_lock_filter_core.sv
verif/tb_frame_timestamp_lock_filter_core.sv
